// ----- sv/bts_pkg.sv -----
// ----------------------------------------------------------------------------
// bts_pkg
// Shared types and codes of the burst transfer sender controller.
// ----------------------------------------------------------------------------
package bts_pkg;

	localparam int SEQ_BITS_DEF = 24;
	localparam int CB_BITS      = 13;
	localparam int SIZE_BITS    = 24;
	localparam int ID_BITS      = 32;
	localparam int DIV_BITS     = SIZE_BITS + 1;

	localparam logic [CB_BITS-1:0]   CHUNK_BYTES_RST = 13'd128;
	localparam logic [CB_BITS-1:0]   CB_MAX          = 13'd4096;
	localparam logic [7:0]           RETRY_RST       = 8'd5;
	localparam logic [7:0]           CNT8_MAX        = 8'hFF;
	localparam logic [SIZE_BITS-1:0] MAX24           = 24'hFFFFFF;

	// input event codes
	localparam logic [3:0] FN_START    = 4'd0;
	localparam logic [3:0] FN_ACCEPT   = 4'd1;
	localparam logic [3:0] FN_MISSING  = 4'd2;
	localparam logic [3:0] FN_DONE     = 4'd3;
	localparam logic [3:0] FN_RCANCEL  = 4'd4;
	localparam logic [3:0] FN_LCANCEL  = 4'd5;
	localparam logic [3:0] FN_OFFER_TO = 4'd6;
	localparam logic [3:0] FN_TICK     = 4'd7;
	localparam logic [3:0] FN_MISS_TO  = 4'd8;

	// result actions
	localparam logic [3:0] ACT_NONE     = 4'd0;
	localparam logic [3:0] ACT_OFFER    = 4'd1;
	localparam logic [3:0] ACT_CHUNK    = 4'd2;
	localparam logic [3:0] ACT_ENDBURST = 4'd3;
	localparam logic [3:0] ACT_CANCEL   = 4'd4;
	localparam logic [3:0] ACT_FAILED   = 4'd5;
	localparam logic [3:0] ACT_COMPLETE = 4'd6;
	localparam logic [3:0] ACT_BSTART   = 4'd7;

	// failure causes
	localparam logic [2:0] CS_NONE     = 3'd0;
	localparam logic [2:0] CS_BUSY     = 3'd1;
	localparam logic [2:0] CS_NOACCEPT = 3'd2;
	localparam logic [2:0] CS_NORESP   = 3'd3;
	localparam logic [2:0] CS_LCANCEL  = 3'd4;
	localparam logic [2:0] CS_RCANCEL  = 3'd5;

	// timer arm requests
	localparam logic [1:0] TM_NONE  = 2'd0;
	localparam logic [1:0] TM_OFFER = 2'd1;
	localparam logic [1:0] TM_GAP   = 2'd2;
	localparam logic [1:0] TM_MISS  = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_CHUNK = 2'd0;
	localparam logic [1:0] CFG_OFFER = 2'd1;
	localparam logic [1:0] CFG_GAP   = 2'd2;

	typedef enum logic [4:0] {
		PH_IDLE  = 5'b00001,
		PH_OFFER = 5'b00010,
		PH_BURST = 5'b00100,
		PH_AWAIT = 5'b01000,
		PH_GAP   = 5'b10000
	} phase_t;

	typedef enum logic [4:0] {
		SQ_IDLE  = 5'b00001,
		SQ_EXEC  = 5'b00010,
		SQ_CALC  = 5'b00100,
		SQ_EMIT1 = 5'b01000,
		SQ_EMIT2 = 5'b10000
	} seq_state_t;

	typedef enum logic {
		OP_MUL = 1'b0,
		OP_DIV = 1'b1
	} md_op_t;

	typedef struct packed {
		logic   start;
		md_op_t op;
	} md_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} md_stat_t;

	typedef struct packed {
		logic [3:0]           action;
		logic [2:0]           cause;
		logic [1:0]           timer;
		logic [SIZE_BITS-1:0] progress;
	} res_t;

endpackage

// ----- sv/burst_transfer_sender_control.sv -----
// ----------------------------------------------------------------------------
// burst_transfer_sender_control
// Sender side of a chunked burst file transfer with selective retransmission.
// ----------------------------------------------------------------------------
// One event is taken at a time. A start event runs the serial divider that
// works out the chunk count one quotient bit a cycle (25 steps). An event that
// sends a chunk frame runs the 13-step shift-add multiply of sequence number
// by chunk size for the byte offset. Both iterations share one adder. in_ready
// is high between events; the last result of an event may still sit in the
// output register while the next event is taken. Up to two results come out
// per event, the final one flagged by last.
module burst_transfer_sender_control #(
	parameter int SEQ_BITS = bts_pkg::SEQ_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  func,
	input  logic [31:0] file_id,
	input  logic [23:0] file_size,
	input  logic [23:0] missing_seq,
	input  logic        list_last,
	input  logic        list_empty,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  action,
	output logic [2:0]  fail_cause,
	output logic [23:0] chunk_seq,
	output logic [23:0] chunk_offset,
	output logic [12:0] chunk_len,
	output logic [23:0] chunk_total,
	output logic [31:0] out_id,
	output logic [23:0] progress,
	output logic [1:0]  timer_arm,
	output logic        last
);

	localparam int PW = SEQ_BITS + bts_pkg::CB_BITS;
	localparam int CW = (PW > bts_pkg::SIZE_BITS) ? PW : bts_pkg::SIZE_BITS;
	localparam int DW = bts_pkg::DIV_BITS;

	// configuration
	logic [12:0] chunk_bytes_q;
	logic [7:0]  max_offer_q, max_gap_q;
	logic [12:0] cb_eff;

	// transfer state
	bts_pkg::phase_t     phase_q;
	logic [31:0]         cur_id_q;
	logic [23:0]         cur_size_q;
	logic [23:0]         total_count_q;
	logic [SEQ_BITS-1:0] burst_seq_q;
	logic [7:0]          offer_tries_q, gap_rounds_q;

	// sequencer and latched item
	bts_pkg::seq_state_t seq_q;
	logic [3:0]          func_q;
	logic [31:0]         id_q;
	logic [23:0]         size_q;
	logic [23:0]         mseq_q;
	logic                lst_q, empty_q;
	bts_pkg::md_op_t     calc_op_q;
	logic [SEQ_BITS-1:0] calc_seq_q;
	bts_pkg::res_t       res1_q, res2_q;
	logic [1:0]          n_q;
	logic [23:0]         chk_off_q;
	logic [12:0]         chk_len_q;

	// output register
	logic        out_valid_q;
	logic [3:0]  action_q;
	logic [2:0]  cause_q;
	logic [23:0] cseq_q, coff_q, ctotal_q, prog_q;
	logic [12:0] clen_q;
	logic [31:0] oid_q;
	logic [1:0]  timer_q;
	logic        last_q;

	// exec decode
	bts_pkg::phase_t     ex_phase;
	bts_pkg::res_t       ex_res1, ex_res2;
	logic [1:0]          ex_n;
	logic                ex_calc, ex_start;
	bts_pkg::md_op_t     ex_op;
	logic [SEQ_BITS-1:0] ex_seq, ex_bseq;
	logic [7:0]          ex_offer, ex_gap, offer_inc, gap_inc;
	logic                match;
	logic [31:0]         mseq_ext, bseq_ext, bseq_inc, cseq_ext;
	logic [SEQ_BITS-1:0] mseq;

	// shared unit
	bts_pkg::md_cmd_t  md_cmd;
	bts_pkg::md_stat_t md_stat;
	logic [PW-1:0]     md_prod;
	logic [23:0]       md_quot;
	logic [DW-1:0]     dividend;

	// chunk finish
	logic [CW-1:0] off_w, size_w, rem_w;
	logic [23:0]   rem24, off_sat;
	logic [12:0]   len_c;

	logic slot_free, load1, load2;
	bts_pkg::res_t ld_res;

	function automatic bts_pkg::res_t mk_res(logic [3:0] a, logic [2:0] c, logic [1:0] t,
	                                         logic [23:0] p);
		bts_pkg::res_t r;
		r.action   = a;
		r.cause    = c;
		r.timer    = t;
		r.progress = p;
		return r;
	endfunction

	assign cfg_ready = 1'b1;
	assign in_ready  = (seq_q == bts_pkg::SQ_IDLE);

	assign cb_eff = (chunk_bytes_q == '0) ? 13'd1 :
	                (chunk_bytes_q > bts_pkg::CB_MAX) ? bts_pkg::CB_MAX : chunk_bytes_q;

	assign match     = (id_q == cur_id_q);
	assign offer_inc = (offer_tries_q != bts_pkg::CNT8_MAX) ? offer_tries_q + 8'd1 : offer_tries_q;
	assign gap_inc   = (gap_rounds_q != bts_pkg::CNT8_MAX) ? gap_rounds_q + 8'd1 : gap_rounds_q;
	assign mseq_ext  = 32'(mseq_q);
	assign mseq      = mseq_ext[SEQ_BITS-1:0];
	assign bseq_ext  = 32'(burst_seq_q);
	assign bseq_inc  = bseq_ext + 32'd1;
	assign cseq_ext  = 32'(calc_seq_q);

	always_comb begin
		ex_phase = phase_q;
		ex_res1  = '0;
		ex_res2  = '0;
		ex_n     = 2'd0;
		ex_calc  = 1'b0;
		ex_start = 1'b0;
		ex_op    = bts_pkg::OP_MUL;
		ex_seq   = burst_seq_q;
		ex_bseq  = burst_seq_q;
		ex_offer = offer_tries_q;
		ex_gap   = gap_rounds_q;
		case (func_q)
			bts_pkg::FN_START: begin
				if (phase_q != bts_pkg::PH_IDLE) begin
					ex_n    = 2'd1;
					ex_res1 = mk_res(bts_pkg::ACT_FAILED, bts_pkg::CS_BUSY, bts_pkg::TM_NONE, '0);
				end else begin
					ex_start = 1'b1;
					ex_phase = bts_pkg::PH_OFFER;
					ex_bseq  = '0;
					ex_offer = '0;
					ex_gap   = '0;
					ex_calc  = 1'b1;
					ex_op    = bts_pkg::OP_DIV;
					ex_n     = 2'd1;
					ex_res1  = mk_res(bts_pkg::ACT_OFFER, bts_pkg::CS_NONE, bts_pkg::TM_OFFER, '0);
				end
			end
			bts_pkg::FN_ACCEPT: begin
				if (match && phase_q == bts_pkg::PH_OFFER) begin
					ex_phase = bts_pkg::PH_BURST;
					ex_n     = 2'd1;
					ex_res1  = mk_res(bts_pkg::ACT_BSTART, bts_pkg::CS_NONE, bts_pkg::TM_GAP, '0);
				end
			end
			bts_pkg::FN_MISSING: begin
				if (match && (phase_q == bts_pkg::PH_AWAIT || phase_q == bts_pkg::PH_GAP)) begin
					if (phase_q == bts_pkg::PH_AWAIT && empty_q) begin
						ex_phase = bts_pkg::PH_IDLE;
						ex_n     = 2'd1;
						ex_res1  = mk_res(bts_pkg::ACT_COMPLETE, bts_pkg::CS_NONE,
						                  bts_pkg::TM_NONE, '0);
					end else begin
						ex_calc = 1'b1;
						ex_seq  = mseq;
						ex_res1 = mk_res(bts_pkg::ACT_CHUNK, bts_pkg::CS_NONE, bts_pkg::TM_GAP, '0);
						if (lst_q) begin
							ex_phase = bts_pkg::PH_AWAIT;
							ex_n     = 2'd2;
							ex_res2  = mk_res(bts_pkg::ACT_ENDBURST, bts_pkg::CS_NONE,
							                  bts_pkg::TM_MISS, '0);
						end else begin
							ex_phase = bts_pkg::PH_GAP;
							ex_n     = 2'd1;
						end
					end
				end
			end
			bts_pkg::FN_DONE: begin
				if (match && phase_q == bts_pkg::PH_AWAIT) begin
					ex_phase = bts_pkg::PH_IDLE;
					ex_n     = 2'd1;
					ex_res1  = mk_res(bts_pkg::ACT_COMPLETE, bts_pkg::CS_NONE, bts_pkg::TM_NONE, '0);
				end
			end
			bts_pkg::FN_RCANCEL: begin
				if (match && phase_q != bts_pkg::PH_IDLE) begin
					ex_phase = bts_pkg::PH_IDLE;
					ex_n     = 2'd1;
					ex_res1  = mk_res(bts_pkg::ACT_FAILED, bts_pkg::CS_RCANCEL, bts_pkg::TM_NONE, '0);
				end
			end
			bts_pkg::FN_LCANCEL: begin
				if (phase_q != bts_pkg::PH_IDLE) begin
					ex_phase = bts_pkg::PH_IDLE;
					ex_n     = 2'd2;
					ex_res1  = mk_res(bts_pkg::ACT_CANCEL, bts_pkg::CS_NONE, bts_pkg::TM_NONE, '0);
					ex_res2  = mk_res(bts_pkg::ACT_FAILED, bts_pkg::CS_LCANCEL, bts_pkg::TM_NONE, '0);
				end
			end
			bts_pkg::FN_OFFER_TO: begin
				if (phase_q == bts_pkg::PH_OFFER) begin
					ex_offer = offer_inc;
					ex_n     = 2'd1;
					if (offer_inc >= max_offer_q) begin
						ex_phase = bts_pkg::PH_IDLE;
						ex_res1  = mk_res(bts_pkg::ACT_FAILED, bts_pkg::CS_NOACCEPT,
						                  bts_pkg::TM_NONE, '0);
					end else begin
						ex_res1 = mk_res(bts_pkg::ACT_OFFER, bts_pkg::CS_NONE, bts_pkg::TM_OFFER, '0);
					end
				end
			end
			bts_pkg::FN_TICK: begin
				if (phase_q == bts_pkg::PH_BURST) begin
					ex_n = 2'd1;
					if (bseq_ext >= 32'(total_count_q)) begin
						ex_phase = bts_pkg::PH_AWAIT;
						ex_res1  = mk_res(bts_pkg::ACT_ENDBURST, bts_pkg::CS_NONE,
						                  bts_pkg::TM_MISS, '0);
					end else begin
						ex_calc = 1'b1;
						ex_seq  = burst_seq_q;
						ex_bseq = burst_seq_q + SEQ_BITS'(1);
						ex_res1 = mk_res(bts_pkg::ACT_CHUNK, bts_pkg::CS_NONE, bts_pkg::TM_GAP,
						                 bseq_inc[23:0]);
					end
				end
			end
			bts_pkg::FN_MISS_TO: begin
				if (phase_q == bts_pkg::PH_AWAIT) begin
					ex_gap = gap_inc;
					ex_n   = 2'd1;
					if (gap_inc >= max_gap_q) begin
						ex_phase = bts_pkg::PH_IDLE;
						ex_res1  = mk_res(bts_pkg::ACT_FAILED, bts_pkg::CS_NORESP, bts_pkg::TM_NONE, '0);
					end else begin
						ex_res1 = mk_res(bts_pkg::ACT_ENDBURST, bts_pkg::CS_NONE, bts_pkg::TM_MISS, '0);
					end
				end
			end
			default: begin
			end
		endcase
	end

	// chunk count needs ceil(size / cb): divide size + cb - 1
	assign dividend = DW'(size_q) + DW'(cb_eff) - DW'(1);

	assign md_cmd.start = (seq_q == bts_pkg::SQ_EXEC) && ex_calc;
	assign md_cmd.op    = ex_op;

	bts_muldiv #(
		.SEQ_BITS (SEQ_BITS)
	) u_muldiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (md_cmd),
		.seq      (ex_seq),
		.cb       (cb_eff),
		.dividend (dividend),
		.stat     (md_stat),
		.prod     (md_prod),
		.quot     (md_quot)
	);

	// offset saturation and chunk length clipping
	assign off_w   = CW'(md_prod);
	assign size_w  = CW'(cur_size_q);
	assign rem_w   = size_w - off_w;
	assign rem24   = rem_w[23:0];
	assign off_sat = (off_w > CW'(bts_pkg::MAX24)) ? bts_pkg::MAX24 : off_w[23:0];
	assign len_c   = (off_w >= size_w) ? 13'd0 :
	                 (rem24 > 24'(cb_eff)) ? cb_eff : rem24[12:0];

	assign slot_free = !out_valid_q || out_ready;
	assign load1     = (seq_q == bts_pkg::SQ_EMIT1) && slot_free;
	assign load2     = (seq_q == bts_pkg::SQ_EMIT2) && slot_free;
	assign ld_res    = load2 ? res2_q : res1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_bytes_q <= bts_pkg::CHUNK_BYTES_RST;
			max_offer_q   <= bts_pkg::RETRY_RST;
			max_gap_q     <= bts_pkg::RETRY_RST;
			phase_q       <= bts_pkg::PH_IDLE;
			cur_id_q      <= '0;
			cur_size_q    <= '0;
			total_count_q <= '0;
			burst_seq_q   <= '0;
			offer_tries_q <= '0;
			gap_rounds_q  <= '0;
			seq_q         <= bts_pkg::SQ_IDLE;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					bts_pkg::CFG_CHUNK: chunk_bytes_q <= cfg_data;
					bts_pkg::CFG_OFFER: max_offer_q   <= cfg_data[7:0];
					bts_pkg::CFG_GAP:   max_gap_q     <= cfg_data[7:0];
					default: begin
					end
				endcase
			end

			if (load1 || load2) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (seq_q)
				bts_pkg::SQ_IDLE: begin
					if (in_valid) begin
						seq_q <= bts_pkg::SQ_EXEC;
					end
				end
				bts_pkg::SQ_EXEC: begin
					phase_q       <= ex_phase;
					burst_seq_q   <= ex_bseq;
					offer_tries_q <= ex_offer;
					gap_rounds_q  <= ex_gap;
					if (ex_start) begin
						cur_id_q   <= id_q;
						cur_size_q <= size_q;
					end
					if (ex_calc) begin
						seq_q <= bts_pkg::SQ_CALC;
					end else if (ex_n != 2'd0) begin
						seq_q <= bts_pkg::SQ_EMIT1;
					end else begin
						seq_q <= bts_pkg::SQ_IDLE;
					end
				end
				bts_pkg::SQ_CALC: begin
					if (md_stat.done) begin
						if (calc_op_q == bts_pkg::OP_DIV) begin
							total_count_q <= (md_quot == '0) ? 24'd1 : md_quot;
						end
						seq_q <= bts_pkg::SQ_EMIT1;
					end
				end
				bts_pkg::SQ_EMIT1: begin
					if (slot_free) begin
						seq_q <= (n_q == 2'd2) ? bts_pkg::SQ_EMIT2 : bts_pkg::SQ_IDLE;
					end
				end
				bts_pkg::SQ_EMIT2: begin
					if (slot_free) begin
						seq_q <= bts_pkg::SQ_IDLE;
					end
				end
				default: begin
					seq_q <= bts_pkg::SQ_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_q  <= func;
			id_q    <= file_id;
			size_q  <= file_size;
			mseq_q  <= missing_seq;
			lst_q   <= list_last;
			empty_q <= list_empty;
		end
		if (seq_q == bts_pkg::SQ_EXEC) begin
			res1_q     <= ex_res1;
			res2_q     <= ex_res2;
			n_q        <= ex_n;
			calc_op_q  <= ex_op;
			calc_seq_q <= ex_seq;
		end
		if (seq_q == bts_pkg::SQ_CALC && md_stat.done && calc_op_q == bts_pkg::OP_MUL) begin
			chk_off_q <= off_sat;
			chk_len_q <= len_c;
		end
		if (load1 || load2) begin
			action_q <= ld_res.action;
			cause_q  <= ld_res.cause;
			timer_q  <= ld_res.timer;
			prog_q   <= ld_res.progress;
			ctotal_q <= total_count_q;
			oid_q    <= cur_id_q;
			last_q   <= load2 || (n_q == 2'd1);
			if (ld_res.action == bts_pkg::ACT_CHUNK) begin
				cseq_q <= cseq_ext[23:0];
				coff_q <= chk_off_q;
				clen_q <= chk_len_q;
			end else begin
				cseq_q <= '0;
				coff_q <= '0;
				clen_q <= '0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign action       = action_q;
	assign fail_cause   = cause_q;
	assign chunk_seq    = cseq_q;
	assign chunk_offset = coff_q;
	assign chunk_len    = clen_q;
	assign chunk_total  = ctotal_q;
	assign out_id       = oid_q;
	assign progress     = prog_q;
	assign timer_arm    = timer_q;
	assign last         = last_q;

	// the shared unit only runs while an event is in flight
	a_unit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		seq_q == bts_pkg::SQ_IDLE |-> !md_stat.busy)
		else $error("shared unit busy while taking events");

	// a finished calculation hands over to the result stage
	a_calc_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q == bts_pkg::SQ_CALC && md_stat.done) |=> seq_q == bts_pkg::SQ_EMIT1)
		else $error("calculation result not emitted");

	// chunk frames always arm the burst gap timer
	a_chunk_timer: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && action == bts_pkg::ACT_CHUNK) |-> timer_arm == bts_pkg::TM_GAP)
		else $error("chunk item without gap timer request");

	// outside the chunk count calculation, a running transfer never has a zero chunk count
	a_total_nz: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != bts_pkg::PH_IDLE && seq_q != bts_pkg::SQ_CALC) |-> total_count_q != '0)
		else $error("zero chunk count during transfer");

endmodule

// ----- sv/bts_muldiv.sv -----
// ----------------------------------------------------------------------------
// bts_muldiv
// Shared shift-add multiplier and restoring divider around one adder.
// ----------------------------------------------------------------------------
module bts_muldiv #(
	parameter int SEQ_BITS = bts_pkg::SEQ_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  bts_pkg::md_cmd_t                      cmd,
	input  logic [SEQ_BITS-1:0]                   seq,
	input  logic [bts_pkg::CB_BITS-1:0]           cb,
	input  logic [bts_pkg::DIV_BITS-1:0]          dividend,
	output bts_pkg::md_stat_t                     stat,
	output logic [SEQ_BITS+bts_pkg::CB_BITS-1:0]  prod,
	output logic [bts_pkg::SIZE_BITS-1:0]         quot
);

	localparam int PW = SEQ_BITS + bts_pkg::CB_BITS;
	localparam int SW = PW + 1;
	localparam int DW = bts_pkg::DIV_BITS;
	localparam int CNT_W = $clog2(DW);

	logic [PW-1:0]    acc_q, mcand_q;
	logic [DW-1:0]    shr_q;
	logic [CNT_W-1:0] cnt_q;
	bts_pkg::md_op_t  op_q;
	logic             busy_q, done_q;

	logic [PW-1:0] r_sh, add_a, add_b;
	logic          add_sub;
	logic [SW-1:0] add_sum;

	// remainder shifted up with the next dividend bit
	assign r_sh    = {acc_q[PW-2:0], shr_q[DW-1]};
	assign add_sub = (op_q == bts_pkg::OP_DIV);
	assign add_a   = add_sub ? r_sh : acc_q;
	assign add_b   = add_sub ? PW'(cb) : mcand_q;
	assign add_sum = {1'b0, add_a} + {1'b0, add_sub ? ~add_b : add_b} + SW'(add_sub);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= bts_pkg::OP_MUL;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				op_q   <= cmd.op;
				cnt_q  <= (cmd.op == bts_pkg::OP_DIV) ? CNT_W'(DW - 1)
				                                      : CNT_W'(bts_pkg::CB_BITS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			acc_q   <= '0;
			mcand_q <= PW'(seq);
			shr_q   <= (cmd.op == bts_pkg::OP_DIV) ? dividend : DW'(cb);
		end else if (busy_q) begin
			if (add_sub) begin
				acc_q <= add_sum[PW] ? add_sum[PW-1:0] : r_sh;
				shr_q <= {shr_q[DW-2:0], add_sum[PW]};
			end else begin
				if (shr_q[0]) begin
					acc_q <= add_sum[PW-1:0];
				end
				mcand_q <= {mcand_q[PW-2:0], 1'b0};
				shr_q   <= {1'b0, shr_q[DW-1:1]};
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign prod      = acc_q;
	assign quot      = shr_q[bts_pkg::SIZE_BITS-1:0];

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the burst transfer sender controller against a cycle-free predictor:
// a directed table of corner cases, then random transfers with offers,
// bursts, missing reports, timeouts, cancels and noise, under several
// register settings and random stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;

	localparam int LIMIT      = 1_000_000;
	localparam int DRAIN      = 48;
	localparam int HOLD       = 300;
	localparam int RAND_ITEMS = 1080;
	localparam int NDIR       = 26;
	localparam int PRED       = -1;
	localparam logic [1:0] CFG_SPARE = 2'd3;

	typedef struct packed {
		logic [3:0]  action;
		logic [2:0]  cause;
		logic [23:0] seq;
		logic [23:0] offset;
		logic [12:0] len;
		logic [23:0] total;
		logic [31:0] id;
		logic [23:0] prog;
		logic [1:0]  timer;
		logic        last;
	} frame_t;

	typedef struct packed {
		logic [3:0]  fn;
		logic [31:0] id;
		logic [23:0] size;
		logic [23:0] mseq;
		logic        lst;
		logic        empty;
	} event_t;

	typedef struct {
		event_t ev;
		int     nexp;
		frame_t exp;
	} row_t;

	localparam frame_t NO_FRAME = '0;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        cfg_valid   = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index   = bts_pkg::CFG_CHUNK;
	logic [12:0] cfg_data    = '0;
	logic        in_valid    = 1'b0;
	logic        in_ready;
	logic [3:0]  func        = bts_pkg::FN_START;
	logic [31:0] file_id     = '0;
	logic [23:0] file_size   = '0;
	logic [23:0] missing_seq = '0;
	logic        list_last   = 1'b0;
	logic        list_empty  = 1'b0;
	logic        out_valid;
	logic        out_ready   = 1'b0;
	logic [3:0]  action;
	logic [2:0]  fail_cause;
	logic [23:0] chunk_seq;
	logic [23:0] chunk_offset;
	logic [12:0] chunk_len;
	logic [23:0] chunk_total;
	logic [31:0] out_id;
	logic [23:0] progress;
	logic [1:0]  timer_arm;
	logic        last;

	burst_transfer_sender_control dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .file_id(file_id), .file_size(file_size),
		.missing_seq(missing_seq), .list_last(list_last), .list_empty(list_empty),
		.out_valid(out_valid), .out_ready(out_ready),
		.action(action), .fail_cause(fail_cause), .chunk_seq(chunk_seq),
		.chunk_offset(chunk_offset), .chunk_len(chunk_len),
		.chunk_total(chunk_total), .out_id(out_id), .progress(progress),
		.timer_arm(timer_arm), .last(last)
	);

	// predicted controller state and registers
	bts_pkg::phase_t st_phase = bts_pkg::PH_IDLE;
	logic [31:0] xfer_id     = '0;
	logic [23:0] xfer_size   = '0;
	logic [23:0] xfer_chunks = '0;
	logic [23:0] next_seq    = '0;
	logic [7:0]  offer_cnt   = '0;
	logic [7:0]  gap_cnt     = '0;
	logic [12:0] reg_chunk   = bts_pkg::CHUNK_BYTES_RST;
	logic [7:0]  reg_offer   = bts_pkg::RETRY_RST;
	logic [7:0]  reg_gap     = bts_pkg::RETRY_RST;

	frame_t frame_q[$];
	frame_t pend[2];
	int     pend_n;

	int   fails      = 0;
	int   busy_items = 0;
	int   xfer_num   = 0;
	int   tx_pct     = 0;
	int   rx_pct     = 0;
	int   cycles     = 0;
	logic calm       = 1'b0;
	logic long_hold  = 1'b0;

	row_t dir_tab [NDIR] = '{
		'{'{bts_pkg::FN_TICK, 32'd0, 24'd0, 24'd0, 1'b0, 1'b0}, 0, NO_FRAME},
		'{'{bts_pkg::FN_DONE, 32'd0, 24'd0, 24'd0, 1'b0, 1'b0}, 0, NO_FRAME},
		'{'{bts_pkg::FN_LCANCEL, 32'd0, 24'd0, 24'd0, 1'b0, 1'b0}, 0, NO_FRAME},
		'{'{4'hF, 32'hFFFF_FFFF, bts_pkg::MAX24, bts_pkg::MAX24, 1'b1, 1'b1}, 0,
			NO_FRAME},
		'{'{bts_pkg::FN_START, 32'hFFFF_FFFF, 24'd0, 24'd0, 1'b0, 1'b0}, 1,
			'{bts_pkg::ACT_OFFER, bts_pkg::CS_NONE, 24'd0, 24'd0, 13'd0, 24'd1,
				32'hFFFF_FFFF, 24'd0, bts_pkg::TM_OFFER, 1'b1}},
		'{'{bts_pkg::FN_START, 32'd0, bts_pkg::MAX24, 24'd0, 1'b0, 1'b0}, 1,
			'{bts_pkg::ACT_FAILED, bts_pkg::CS_BUSY, 24'd0, 24'd0, 13'd0, 24'd1,
				32'hFFFF_FFFF, 24'd0, bts_pkg::TM_NONE, 1'b1}},
		'{'{bts_pkg::FN_ACCEPT, 32'd0, 24'd0, 24'd0, 1'b0, 1'b0}, 0, NO_FRAME},
		'{'{bts_pkg::FN_OFFER_TO, 32'd0, 24'd0, 24'd0, 1'b0, 1'b0}, PRED, NO_FRAME},
		'{'{bts_pkg::FN_ACCEPT, 32'hFFFF_FFFF, 24'd0, 24'd0, 1'b0, 1'b0}, PRED,
			NO_FRAME},
		'{'{bts_pkg::FN_TICK, 32'd0, 24'd0, 24'd0, 1'b0, 1'b0}, PRED, NO_FRAME},
		'{'{bts_pkg::FN_TICK, 32'd0, 24'd0, 24'd0, 1'b0, 1'b0}, PRED, NO_FRAME},
		// entry far past the data: offset saturates
		'{'{bts_pkg::FN_MISSING, 32'hFFFF_FFFF, 24'd0, bts_pkg::MAX24, 1'b0, 1'b0},
			PRED, NO_FRAME},
		// empty flag while gap filling is ignored
		'{'{bts_pkg::FN_MISSING, 32'hFFFF_FFFF, 24'd0, 24'd0, 1'b1, 1'b1}, PRED,
			NO_FRAME},
		'{'{bts_pkg::FN_MISS_TO, 32'd0, 24'd0, 24'd0, 1'b0, 1'b0}, PRED, NO_FRAME},
		'{'{bts_pkg::FN_MISSING, 32'hFFFF_FFFF, 24'd0, 24'd0, 1'b0, 1'b1}, PRED,
			NO_FRAME},
		'{'{bts_pkg::FN_START, 32'd1, bts_pkg::MAX24, 24'd0, 1'b0, 1'b0}, PRED,
			NO_FRAME},
		'{'{bts_pkg::FN_RCANCEL, 32'd2, 24'd0, 24'd0, 1'b0, 1'b0}, 0, NO_FRAME},
		'{'{bts_pkg::FN_RCANCEL, 32'd1, 24'd0, 24'd0, 1'b0, 1'b0}, PRED, NO_FRAME},
		'{'{bts_pkg::FN_START, 32'd2, 24'd300, 24'd0, 1'b0, 1'b0}, PRED, NO_FRAME},
		'{'{bts_pkg::FN_LCANCEL, 32'd0, 24'd0, 24'd0, 1'b0, 1'b0}, PRED, NO_FRAME},
		'{'{bts_pkg::FN_START, 32'd3, 24'd1000, 24'd0, 1'b0, 1'b0}, PRED, NO_FRAME},
		'{'{bts_pkg::FN_OFFER_TO, 32'd0, 24'd0, 24'd0, 1'b0, 1'b0}, PRED, NO_FRAME},
		'{'{bts_pkg::FN_OFFER_TO, 32'd0, 24'd0, 24'd0, 1'b0, 1'b0}, PRED, NO_FRAME},
		'{'{bts_pkg::FN_OFFER_TO, 32'd0, 24'd0, 24'd0, 1'b0, 1'b0}, PRED, NO_FRAME},
		'{'{bts_pkg::FN_OFFER_TO, 32'd0, 24'd0, 24'd0, 1'b0, 1'b0}, PRED, NO_FRAME},
		'{'{bts_pkg::FN_OFFER_TO, 32'd0, 24'd0, 24'd0, 1'b0, 1'b0}, PRED, NO_FRAME}
	};

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	function automatic int unsigned chunk_size();
		if (reg_chunk == '0) return 1;
		if (reg_chunk > bts_pkg::CB_MAX) return bts_pkg::CB_MAX;
		return reg_chunk;
	endfunction

	function automatic frame_t status_frame(input logic [3:0] act, input logic [2:0] cause,
			input logic [1:0] tm, input logic [23:0] prog);
		frame_t f;
		f = '0;
		f.action = act;
		f.cause  = cause;
		f.total  = xfer_chunks;
		f.id     = xfer_id;
		f.prog   = prog;
		f.timer  = tm;
		return f;
	endfunction

	function automatic frame_t chunk_frame(input logic [23:0] seq, input logic [23:0] prog);
		longint unsigned cb, off, len;
		frame_t f;
		cb  = chunk_size();
		off = 64'(seq) * cb;
		len = 0;
		if (off < 64'(xfer_size)) begin
			len = 64'(xfer_size) - off;
			if (len > cb) len = cb;
		end
		f = status_frame(bts_pkg::ACT_CHUNK, bts_pkg::CS_NONE, bts_pkg::TM_GAP, prog);
		f.seq    = seq;
		f.offset = (off > 64'(bts_pkg::MAX24)) ? bts_pkg::MAX24 : off[23:0];
		f.len    = len[12:0];
		return f;
	endfunction

	function automatic void emit(input frame_t f);
		pend[pend_n] = f;
		pend_n++;
	endfunction

	// results of one accepted item, state updated as the controller would
	function automatic void predict(input event_t ev);
		logic hit;
		int unsigned cb;
		hit    = (ev.id == xfer_id);
		pend_n = 0;
		case (ev.fn)
			bts_pkg::FN_START: begin
				if (st_phase != bts_pkg::PH_IDLE) begin
					emit(status_frame(bts_pkg::ACT_FAILED, bts_pkg::CS_BUSY,
						bts_pkg::TM_NONE, '0));
				end else begin
					cb          = chunk_size();
					xfer_id     = ev.id;
					xfer_size   = ev.size;
					xfer_chunks = 24'((32'(ev.size) + cb - 1) / cb);
					if (xfer_chunks == '0) xfer_chunks = 24'd1;
					next_seq  = '0;
					offer_cnt = '0;
					gap_cnt   = '0;
					st_phase  = bts_pkg::PH_OFFER;
					emit(status_frame(bts_pkg::ACT_OFFER, bts_pkg::CS_NONE,
						bts_pkg::TM_OFFER, '0));
				end
			end
			bts_pkg::FN_ACCEPT: begin
				if (hit && st_phase == bts_pkg::PH_OFFER) begin
					st_phase = bts_pkg::PH_BURST;
					emit(status_frame(bts_pkg::ACT_BSTART, bts_pkg::CS_NONE,
						bts_pkg::TM_GAP, '0));
				end
			end
			bts_pkg::FN_MISSING: begin
				if (hit && (st_phase == bts_pkg::PH_AWAIT || st_phase == bts_pkg::PH_GAP)) begin
					if (st_phase == bts_pkg::PH_AWAIT && ev.empty) begin
						st_phase = bts_pkg::PH_IDLE;
						emit(status_frame(bts_pkg::ACT_COMPLETE, bts_pkg::CS_NONE,
							bts_pkg::TM_NONE, '0));
					end else begin
						st_phase = bts_pkg::PH_GAP;
						emit(chunk_frame(ev.mseq, '0));
						if (ev.lst) begin
							st_phase = bts_pkg::PH_AWAIT;
							emit(status_frame(bts_pkg::ACT_ENDBURST, bts_pkg::CS_NONE,
								bts_pkg::TM_MISS, '0));
						end
					end
				end
			end
			bts_pkg::FN_DONE: begin
				if (hit && st_phase == bts_pkg::PH_AWAIT) begin
					st_phase = bts_pkg::PH_IDLE;
					emit(status_frame(bts_pkg::ACT_COMPLETE, bts_pkg::CS_NONE,
						bts_pkg::TM_NONE, '0));
				end
			end
			bts_pkg::FN_RCANCEL: begin
				if (hit && st_phase != bts_pkg::PH_IDLE) begin
					st_phase = bts_pkg::PH_IDLE;
					emit(status_frame(bts_pkg::ACT_FAILED, bts_pkg::CS_RCANCEL,
						bts_pkg::TM_NONE, '0));
				end
			end
			bts_pkg::FN_LCANCEL: begin
				if (st_phase != bts_pkg::PH_IDLE) begin
					st_phase = bts_pkg::PH_IDLE;
					emit(status_frame(bts_pkg::ACT_CANCEL, bts_pkg::CS_NONE,
						bts_pkg::TM_NONE, '0));
					emit(status_frame(bts_pkg::ACT_FAILED, bts_pkg::CS_LCANCEL,
						bts_pkg::TM_NONE, '0));
				end
			end
			bts_pkg::FN_OFFER_TO: begin
				if (st_phase == bts_pkg::PH_OFFER) begin
					if (offer_cnt != bts_pkg::CNT8_MAX) offer_cnt++;
					if (offer_cnt >= reg_offer) begin
						st_phase = bts_pkg::PH_IDLE;
						emit(status_frame(bts_pkg::ACT_FAILED, bts_pkg::CS_NOACCEPT,
							bts_pkg::TM_NONE, '0));
					end else begin
						emit(status_frame(bts_pkg::ACT_OFFER, bts_pkg::CS_NONE,
							bts_pkg::TM_OFFER, '0));
					end
				end
			end
			bts_pkg::FN_TICK: begin
				if (st_phase == bts_pkg::PH_BURST) begin
					if (next_seq >= xfer_chunks) begin
						st_phase = bts_pkg::PH_AWAIT;
						emit(status_frame(bts_pkg::ACT_ENDBURST, bts_pkg::CS_NONE,
							bts_pkg::TM_MISS, '0));
					end else begin
						emit(chunk_frame(next_seq, next_seq + 24'd1));
						next_seq++;
					end
				end
			end
			bts_pkg::FN_MISS_TO: begin
				if (st_phase == bts_pkg::PH_AWAIT) begin
					if (gap_cnt != bts_pkg::CNT8_MAX) gap_cnt++;
					if (gap_cnt >= reg_gap) begin
						st_phase = bts_pkg::PH_IDLE;
						emit(status_frame(bts_pkg::ACT_FAILED, bts_pkg::CS_NORESP,
							bts_pkg::TM_NONE, '0));
					end else begin
						emit(status_frame(bts_pkg::ACT_ENDBURST, bts_pkg::CS_NONE,
							bts_pkg::TM_MISS, '0));
					end
				end
			end
			default: ;
		endcase
		if (pend_n > 0) pend[pend_n-1].last = 1'b1;
	endfunction

	function automatic event_t mk_ev(input logic [3:0] fn, input logic [31:0] id,
			input logic [23:0] size, input logic [23:0] mseq, input logic lst,
			input logic empty);
		event_t ev;
		ev = '{fn, id, size, mseq, lst, empty};
		return ev;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk) begin
		frame_t want;
		if (arst_n && out_valid && out_ready) begin
			if (frame_q.size() == 0) begin
				$error("result with nothing expected, action %0d", action);
				fails++;
			end else begin
				want = frame_q.pop_front();
				check_field("action", want.action, action);
				check_field("fail_cause", want.cause, fail_cause);
				check_field("chunk_seq", want.seq, chunk_seq);
				check_field("chunk_offset", want.offset, chunk_offset);
				check_field("chunk_len", want.len, chunk_len);
				check_field("chunk_total", want.total, chunk_total);
				check_field("out_id", want.id, out_id);
				check_field("progress", want.prog, progress);
				check_field("timer_arm", want.timer, timer_arm);
				check_field("last", want.last, last);
			end
		end
	end

	// result side: random stall bursts, plus one long hold-off
	initial begin
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_ready <= 1'b0;
				repeat (HOLD) @(posedge clk);
				out_ready <= 1'b1;
				long_hold = 1'b0;
			end else if (!calm && $urandom_range(0, 99) < rx_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send_event(input event_t ev, input int nexp = PRED,
			input frame_t exp = NO_FRAME);
		in_valid    <= 1'b1;
		func        <= ev.fn;
		file_id     <= ev.id;
		file_size   <= ev.size;
		missing_seq <= ev.mseq;
		list_last   <= ev.lst;
		list_empty  <= ev.empty;
		do @(posedge clk); while (!in_ready);
		predict(ev);
		if (pend_n > 0) busy_items++;
		if (nexp < 0) begin
			for (int k = 0; k < pend_n; k++) frame_q.push_back(pend[k]);
		end else if (nexp > 0) begin
			frame_q.push_back(exp);
		end
		if (!calm && $urandom_range(0, 99) < tx_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	task automatic send_noise();
		logic [23:0] mseq;
		if ($urandom_range(0, 11) != 0) return;
		mseq = $urandom_range(0, 1) ? 24'($urandom_range(0, xfer_chunks)) : 24'($urandom);
		send_event(mk_ev(4'($urandom), $urandom_range(0, 1) ? xfer_id : $urandom,
			24'($urandom), mseq, 1'($urandom), 1'($urandom)));
	endtask

	// registers only change with nothing in flight
	task automatic settle();
		in_valid <= 1'b0;
		while (frame_q.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [12:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			bts_pkg::CFG_CHUNK: reg_chunk = data;
			bts_pkg::CFG_OFFER: reg_offer = data[7:0];
			bts_pkg::CFG_GAP:   reg_gap   = data[7:0];
			default: ;
		endcase
	endtask

	task automatic reconfigure(input int round);
		logic [12:0] cb;
		logic [7:0]  ro, rg;
		case (round)
			0: begin cb = '0; ro = 8'd0; rg = 8'd0; end
			1: begin cb = 13'h1FFF; ro = bts_pkg::CNT8_MAX; rg = bts_pkg::CNT8_MAX; end
			2: begin cb = 13'd1; ro = 8'd1; rg = 8'd1; end
			3: begin cb = bts_pkg::CB_MAX; ro = 8'd3; rg = 8'd2; end
			4: begin
				cb = bts_pkg::CHUNK_BYTES_RST;
				ro = bts_pkg::RETRY_RST;
				rg = bts_pkg::RETRY_RST;
			end
			default: begin
				cb = ($urandom_range(0, 3) == 0) ? 13'($urandom) : 13'($urandom_range(1, 300));
				ro = $urandom_range(0, 1) ? 8'($urandom_range(0, 8)) : 8'($urandom);
				rg = $urandom_range(0, 1) ? 8'($urandom_range(0, 8)) : 8'($urandom);
			end
		endcase
		write_reg(bts_pkg::CFG_CHUNK, cb);
		write_reg(bts_pkg::CFG_OFFER, {5'($urandom), ro});
		write_reg(bts_pkg::CFG_GAP, {5'($urandom), rg});
		if (round == 4 || $urandom_range(0, 7) == 0) write_reg(CFG_SPARE, 13'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// one transfer from start to its end, with noise mixed in
	task automatic run_transfer();
		int n, ne, steps;
		logic [23:0] size, seq;
		int unsigned cb;
		rx_pct = 15 * $urandom_range(0, 3);
		tx_pct = 15 * $urandom_range(0, 3);
		cb = chunk_size();
		case ($urandom_range(0, 15))
			0: size = 24'($urandom);
			1: size = '0;
			2: size = bts_pkg::MAX24;
			default: size = 24'($urandom_range(0, cb * 10));
		endcase
		send_event(mk_ev(bts_pkg::FN_START, $urandom, size, 24'($urandom), 1'($urandom),
			1'($urandom)));

		n = $urandom_range(0, 3);
		if (reg_offer <= 6 && $urandom_range(0, 3) == 0) n = reg_offer;
		for (int i = 0; i < n && st_phase == bts_pkg::PH_OFFER; i++) begin
			send_noise();
			send_event(mk_ev(bts_pkg::FN_OFFER_TO, $urandom, 24'($urandom), 24'($urandom),
				1'($urandom), 1'($urandom)));
		end
		if ($urandom_range(0, 3) == 0)
			send_event(mk_ev(bts_pkg::FN_ACCEPT, xfer_id ^ (32'd1 << $urandom_range(0, 31)),
				'0, '0, 1'b0, 1'b0));
		if (st_phase == bts_pkg::PH_OFFER)
			send_event(mk_ev(bts_pkg::FN_ACCEPT, xfer_id, 24'($urandom), '0, 1'b0, 1'b0));

		steps = 0;
		while (st_phase == bts_pkg::PH_BURST && steps < 48) begin
			send_noise();
			send_event(mk_ev(bts_pkg::FN_TICK, $urandom, 24'($urandom), 24'($urandom),
				1'($urandom), 1'($urandom)));
			steps++;
		end

		n = $urandom_range(0, 3);
		for (int r = 0; r < n && st_phase == bts_pkg::PH_AWAIT; r++) begin
			if ($urandom_range(0, 3) == 0) begin
				send_event(mk_ev(bts_pkg::FN_MISS_TO, $urandom, '0, '0, 1'b0, 1'b0));
			end else begin
				ne = $urandom_range(1, 5);
				for (int k = 0; k < ne; k++) begin
					seq = ($urandom_range(0, 7) == 0) ? 24'($urandom)
						: 24'($urandom_range(0, xfer_chunks));
					send_event(mk_ev(bts_pkg::FN_MISSING, xfer_id, 24'($urandom), seq,
						k == ne - 1, (k > 0) ? 1'($urandom) : 1'b0));
				end
			end
		end

		if (st_phase == bts_pkg::PH_AWAIT) begin
			case ($urandom_range(0, 5))
				0, 1: send_event(mk_ev(bts_pkg::FN_DONE, xfer_id, '0, '0, 1'b0, 1'b0));
				2: send_event(mk_ev(bts_pkg::FN_MISSING, xfer_id, '0, 24'($urandom),
					1'($urandom), 1'b1));
				3: begin
					steps = 0;
					while (st_phase == bts_pkg::PH_AWAIT && steps < 8) begin
						send_event(mk_ev(bts_pkg::FN_MISS_TO, $urandom, '0, '0, 1'b0, 1'b0));
						steps++;
					end
				end
				4: send_event(mk_ev(bts_pkg::FN_RCANCEL, xfer_id, '0, '0, 1'b0, 1'b0));
				default: send_event(mk_ev(bts_pkg::FN_LCANCEL, $urandom, '0, '0, 1'b0, 1'b0));
			endcase
		end
		if (st_phase != bts_pkg::PH_IDLE)
			send_event(mk_ev($urandom_range(0, 1) ? bts_pkg::FN_LCANCEL : bts_pkg::FN_RCANCEL,
				xfer_id, '0, '0, 1'b0, 1'b0));
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		tx_pct = 25;
		rx_pct = 25;
		for (int i = 0; i < NDIR; i++)
			send_event(dir_tab[i].ev, dir_tab[i].nexp, dir_tab[i].exp);

		while (busy_items < RAND_ITEMS) begin
			if (xfer_num % 4 == 0) begin
				settle();
				reconfigure(xfer_num / 4);
			end
			// fill the block while results are held back
			if (xfer_num == 0) long_hold = 1'b1;
			if (busy_items > RAND_ITEMS - 150) calm = 1'b1;
			run_transfer();
			xfer_num++;
		end

		in_valid <= 1'b0;
		while (frame_q.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (fails == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// ----- files.f -----
sv/bts_pkg.sv
sv/bts_muldiv.sv
sv/burst_transfer_sender_control.sv
tb/testbench.sv
